### sv/mqrb_pkg.sv
// ----------------------------------------------------------------------------
// mqrb_pkg: shared types and codes for the multi-queue ring buffer
// Request and result payload structs, operation and status codes.
// ----------------------------------------------------------------------------
package mqrb_pkg;

  localparam int FUNC_W   = 1;
  localparam int QIDX_W   = 5;
  localparam int QIDX_N   = 1 << QIDX_W;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [QIDX_W-1:0] queue_index;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [FILL_W-1:0]   fill_count;
  } out_result_t;

endpackage

### sv/multi_queue_ring_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_ring_buffer: bank of circular FIFOs over one shared word store
// A request accepted in ST_IDLE or ST_RESULT passes through ST_ACCESS and has
// its result strobed in ST_RESULT; the receiver cannot stall. busy holds off
// the next request in ST_ACCESS, for the read-modify-write of the per-queue
// pointer memory (read on accept, then write-back plus word access).
// Reset clears the per-queue valid bits (empty queues) at once, no clearing
// pass; the word store is not initialized.
// ----------------------------------------------------------------------------
module multi_queue_ring_buffer #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 32,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  mqrb_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output mqrb_pkg::out_result_t out_result
);
  import mqrb_pkg::*;

  // Widths derived from the bank geometry
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int WORDS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Per-queue bookkeeping, one entry of the pointer memory
  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] count;
  } meta_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // Queue index folding: table of index mod NUM_QUEUES, built at elaboration
  logic [QW-1:0] qmap [QIDX_N];
  for (genvar i = 0; i < QIDX_N; i++) begin : g_qmap
    assign qmap[i] = QW'(i % NUM_QUEUES);
  end

  // Memories
  meta_t           meta_mem [NUM_QUEUES];
  logic [WORD_WIDTH-1:0] word_mem [WORDS];
  // Per-queue valid bits: a never-written queue reads as empty
  logic [NUM_QUEUES-1:0] meta_vld_r;

  // Captured request
  logic [FUNC_W-1:0]     func_r;
  logic [QW-1:0]         q_r;
  logic [WORD_WIDTH-1:0] wdata_r;

  // Registered read data
  meta_t                 meta_rd_r;
  logic                  meta_rd_vld_r;
  logic [WORD_WIDTH-1:0] word_rd_r;

  // Result registers
  logic [STATUS_W-1:0]   status_r;
  logic [CW-1:0]         fill_r;
  logic                  pop_ok_r;

  logic                  accept;
  logic [QW-1:0]         in_q;

  // Read-modify-write of the current queue (valid in ST_ACCESS)
  meta_t                 meta_cur;
  meta_t                 meta_new;
  logic                  push_ok;
  logic                  pop_ok;
  logic [STATUS_W-1:0]   status_nxt;
  logic [PW-1:0]         slot;
  logic [AW-1:0]         word_addr;
  logic                  in_access;

  assign busy      = (state_r == ST_ACCESS);
  assign accept    = start && !busy;
  assign in_q      = qmap[in_item.queue_index];
  assign in_access = (state_r == ST_ACCESS);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    meta_cur   = meta_rd_vld_r ? meta_rd_r : '0;
    meta_new   = meta_cur;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    status_nxt = STATUS_DONE;
    if (func_r == FUNC_PUSH) begin
      if (meta_cur.count == CW'(QUEUE_DEPTH)) begin
        status_nxt = STATUS_FULL;
      end else begin
        push_ok        = 1'b1;
        meta_new.tail  = next_slot(meta_cur.tail);
        meta_new.count = meta_cur.count + CW'(1);
      end
    end else begin
      if (meta_cur.count == '0) begin
        status_nxt = STATUS_EMPTY;
      end else begin
        pop_ok         = 1'b1;
        meta_new.head  = next_slot(meta_cur.head);
        meta_new.count = meta_cur.count - CW'(1);
      end
    end
    slot      = (func_r == FUNC_PUSH) ? meta_cur.tail : meta_cur.head;
    word_addr = AW'(AW'(q_r) * AW'(QUEUE_DEPTH) + AW'(slot));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_ACCESS;
      ST_ACCESS: state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = start ? ST_ACCESS : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      if (in_access) begin
        status_r <= status_nxt;
        fill_r   <= meta_new.count;
        pop_ok_r <= pop_ok;
      end
    end
  end

  // Queue valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
    end else if (in_access) begin
      meta_vld_r[q_r] <= 1'b1;
    end
  end

  // Request capture and pointer memory read on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r        <= in_item.func;
      q_r           <= in_q;
      wdata_r       <= WORD_WIDTH'(in_item.write_data);
      meta_rd_r     <= meta_mem[in_q];
      meta_rd_vld_r <= meta_vld_r[in_q];
    end
  end

  // Pointer memory write-back
  always_ff @(posedge clk) begin
    if (in_access) begin
      meta_mem[q_r] <= meta_new;
    end
  end

  // Word store: write on push, registered read on pop
  always_ff @(posedge clk) begin
    if (in_access && push_ok) begin
      word_mem[word_addr] <= wdata_r;
    end
    if (in_access && pop_ok) begin
      word_rd_r <= word_mem[word_addr];
    end
  end

  assign out_valid             = (state_r == ST_RESULT);
  assign out_result.status     = status_r;
  assign out_result.read_data  = pop_ok_r ? DATA_W'(word_rd_r) : '0;
  assign out_result.fill_count = FILL_W'(fill_r);

endmodule

### test/tb_multi_queue_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_ring_buffer: self-checking bench for the queue bank
// Drives push/pop requests through the start/busy handshake and checks every
// strobed result, field by field, against a behavioral copy of the 32 queues.
// A short table of directed requests runs first, then phased random traffic.
// ----------------------------------------------------------------------------
module tb_multi_queue_ring_buffer;
  import mqrb_pkg::*;

  localparam int QDEPTH        = 16;
  localparam int NQUEUES       = 32;
  localparam int WWIDTH        = 32;
  localparam int PTR_W         = $clog2(QDEPTH);
  localparam int RANDOM_BLOCKS = 30;
  localparam int BLOCK_LEN     = 50;
  localparam int DRAIN_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_result_t out_result;

  multi_queue_ring_buffer #(
    .QUEUE_DEPTH (QDEPTH),
    .NUM_QUEUES  (NQUEUES),
    .WORD_WIDTH  (WWIDTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the queue bank
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0]  ring_head  [NQUEUES];
  logic [PTR_W-1:0]  ring_tail  [NQUEUES];
  logic [FILL_W-1:0] ring_count [NQUEUES];
  logic [DATA_W-1:0] ring_words [NQUEUES][QDEPTH];

  // results owed by the block, oldest first
  out_result_t pending_results [$];

  // a directed row may pin its result instead of taking the shadow's answer
  bit          pin_expected;
  out_result_t pinned_result;

  int errors;
  int n_requests;
  int n_directed;
  int n_results;
  int n_full;
  int n_empty;
  int n_words_out;

  typedef struct {
    in_item_t    item;
    int          reps;      // repeated in sequence, push write_data stepped by one
    bit          typed;
    out_result_t result;
  } stim_row_t;

  stim_row_t rows [$];

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Applies one request to the shadow bank and returns the result it owes.
  // Rejected requests leave every pointer and count alone.
  function automatic out_result_t apply_request(in_item_t req);
    out_result_t res;
    int          q;
    q              = int'(req.queue_index) % NQUEUES;
    res.status     = STATUS_DONE;
    res.read_data  = '0;
    if (req.func == FUNC_PUSH) begin
      if (ring_count[q] >= FILL_W'(QDEPTH)) begin
        res.status = STATUS_FULL;
      end else begin
        ring_words[q][ring_tail[q]] = req.write_data;
        ring_tail[q]  = ring_next(ring_tail[q]);
        ring_count[q] = ring_count[q] + FILL_W'(1);
      end
    end else begin
      if (ring_count[q] == '0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.read_data = ring_words[q][ring_head[q]];
        ring_head[q]  = ring_next(ring_head[q]);
        ring_count[q] = ring_count[q] - FILL_W'(1);
      end
    end
    res.fill_count = ring_count[q];
    return res;
  endfunction

  function automatic void add_row(logic [FUNC_W-1:0] func, int q, logic [DATA_W-1:0] data,
                                  int reps, bit typed = 1'b0,
                                  logic [STATUS_W-1:0] st = STATUS_DONE,
                                  logic [DATA_W-1:0] rd = '0, int fill = 0);
    stim_row_t r;
    r.item.func              = func;
    r.item.queue_index       = QIDX_W'(q);
    r.item.write_data        = data;
    r.reps                   = reps;
    r.typed                  = typed;
    r.result.status          = st;
    r.result.read_data       = rd;
    r.result.fill_count      = FILL_W'(fill);
    rows.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: record accepted requests, check strobed results.
  // Both happen at the rising edge; inputs only move at the falling edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) begin
        want = apply_request(in_item);
        if (pin_expected) want = pinned_result;
        pending_results.push_back(want);
        n_requests++;
      end
      if (out_valid !== 1'b0 && out_valid !== 1'b1) begin
        $display("%0t: out_valid is unknown: expected 0 or 1, actual %b", $time, out_valid);
        errors++;
      end else if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d data %h fill %0d",
                   $time, out_result.status, out_result.read_data, out_result.fill_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (out_result.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_result.status);
            errors++;
          end
          if (out_result.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, out_result.read_data);
            errors++;
          end
          if (out_result.fill_count !== want.fill_count) begin
            $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                     $time, want.fill_count, out_result.fill_count);
            errors++;
          end
          if (want.status == STATUS_FULL) n_full++;
          if (want.status == STATUS_EMPTY) n_empty++;
          if (want.status == STATUS_DONE && out_result.read_data !== 'x) n_words_out++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  bit quiet;   // no idle cycles between requests in this stretch

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(19);
  endfunction

  // Presents one request from the next falling edge and holds it until taken.
  // start stays high across back-to-back requests, so it only ever gets one
  // assignment per falling edge.
  task automatic issue(in_item_t req, int gap, bit typed, out_result_t typed_res);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_item       <= req;
    pin_expected  = typed;
    pinned_result = typed_res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drops start and waits for every owed result, bounded.
  task automatic wait_results_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    in_item_t          req;
    out_result_t       no_pin;
    int                k;
    int                blk;
    int                push_pct;
    int                hot_a;
    int                hot_b;
    bit                narrow;
    int                q;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    pin_expected  = 1'b0;
    pinned_result = '0;
    no_pin        = '0;
    errors        = 0;
    n_requests    = 0;
    n_directed    = 0;
    n_results     = 0;
    n_full        = 0;
    n_empty       = 0;
    n_words_out   = 0;
    quiet         = 1'b0;
    for (int i = 0; i < NQUEUES; i++) begin
      ring_head[i]  = '0;
      ring_tail[i]  = '0;
      ring_count[i] = '0;
    end

    // ---- directed table ----------------------------------------------------
    // pops on empty queues straight out of reset, lowest and highest index
    add_row(FUNC_POP,  0,  32'h0000_0000, 1, 1'b1, STATUS_EMPTY, '0, 0);
    add_row(FUNC_POP,  31, 32'hFFFF_FFFF, 1, 1'b1, STATUS_EMPTY, '0, 0);
    // extreme data words in and out
    add_row(FUNC_PUSH, 0,  32'h0000_0000, 1, 1'b1, STATUS_DONE, '0, 1);
    add_row(FUNC_PUSH, 31, 32'hFFFF_FFFF, 1, 1'b1, STATUS_DONE, '0, 1);
    add_row(FUNC_POP,  31, 32'h0000_0000, 1, 1'b1, STATUS_DONE, 32'hFFFF_FFFF, 0);
    add_row(FUNC_POP,  0,  32'hFFFF_FFFF, 1, 1'b1, STATUS_DONE, '0, 0);
    add_row(FUNC_POP,  31, 32'h0000_0000, 1, 1'b1, STATUS_EMPTY, '0, 0);
    // alternating bit patterns on alternating queue index bits
    add_row(FUNC_PUSH, 21, 32'hAAAA_AAAA, 1);
    add_row(FUNC_PUSH, 10, 32'h5555_5555, 1);
    add_row(FUNC_POP,  21, 32'h0000_0000, 1);
    add_row(FUNC_POP,  10, 32'h0000_0000, 1);
    // fill one queue to the top, then a push that must bounce off
    add_row(FUNC_PUSH, 7,  32'h7000_0000, QDEPTH);
    add_row(FUNC_PUSH, 7,  32'h1234_5678, 1, 1'b1, STATUS_FULL, '0, QDEPTH);
    // neighbor queue is untouched by the full one
    add_row(FUNC_PUSH, 8,  32'h8000_0001, 1);
    // drain it again; pointers wrap back to slot zero on the way
    add_row(FUNC_POP,  7,  32'h0000_0000, QDEPTH);
    add_row(FUNC_POP,  7,  32'h0000_0000, 1, 1'b1, STATUS_EMPTY, '0, 0);
    // pop carries junk write_data, which must be ignored
    add_row(FUNC_POP,  8,  32'hFFFF_FFFF, 1);
    // second lap through the wrapped pointers
    add_row(FUNC_PUSH, 7,  32'h0F0F_0F00, 3);
    add_row(FUNC_POP,  7,  32'h0000_0000, 3);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      for (k = 0; k < rows[i].reps; k++) begin
        req = rows[i].item;
        if (req.func == FUNC_PUSH) req.write_data = req.write_data + DATA_W'(k);
        issue(req, draw_gap(), rows[i].typed, rows[i].result);
        n_directed++;
      end
    end

    // ---- random traffic in phases --------------------------------------------
    // Each block picks a push/pop mix and, often, a couple of hot queues so the
    // queues actually reach full and empty rather than hovering near zero.
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        2:       push_pct = 85;
        default: push_pct = 97;
      endcase
      hot_a  = $urandom_range(NQUEUES - 1);
      hot_b  = $urandom_range(NQUEUES - 1);
      narrow = ($urandom_range(3) != 0);
      quiet  = ($urandom_range(3) == 0);

      // halfway: hold off completely until the bank has answered everything
      if (blk == RANDOM_BLOCKS / 2) wait_results_drained();

      for (k = 0; k < BLOCK_LEN; k++) begin
        if (narrow && $urandom_range(9) < 8) q = $urandom_range(1) ? hot_a : hot_b;
        else q = $urandom_range(QIDX_N - 1);
        req.func        = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        req.queue_index = QIDX_W'(q);
        case ($urandom_range(7))
          0:       req.write_data = '0;
          1:       req.write_data = '1;
          default: req.write_data = $urandom;
        endcase
        issue(req, draw_gap(), 1'b0, no_pin);
      end
    end

    // ---- wind down -------------------------------------------------------------
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: missing results: expected %0d more, actual 0 (oldest status %0d fill %0d)",
               $time, pending_results.size(), pending_results[0].status,
               pending_results[0].fill_count);
      errors++;
    end

    $display("Ran %0d requests (%0d from the directed table) over %0d queues;",
             n_requests, n_directed, NQUEUES);
    $display("%0d results checked; rejections seen: %0d on full queues, %0d on empty queues",
             n_results, n_full, n_empty);
    if (errors == 0) begin
      $display("PASS multi_queue_ring_buffer");
    end else begin
      $display("FAIL multi_queue_ring_buffer");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run (every gap at its maximum)
  initial begin
    #2000000;
    $display("FAIL multi_queue_ring_buffer");
    $finish;
  end

endmodule

### sim.f
sv/mqrb_pkg.sv
sv/multi_queue_ring_buffer.sv
test/tb_multi_queue_ring_buffer.sv
